// ===== design/sgf_pkg.sv =====
package sgf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIM_W      = 11;
  localparam int RAD_REG_W  = 2;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_V = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;

  // border handling, any other code behaves as zero padding
  localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RENORM = 2'd2;

  // item kind
  localparam logic KIND_PIXEL = 1'b0;

endpackage

// ===== design/sgf_cmd_fifo.sv =====
module sgf_cmd_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     head,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int PTRW  = $clog2(DEPTH);

  T                mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [PTRW:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == (PTRW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== design/sgf_front.sv =====
module sgf_front #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter type cmd_t     = logic
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_kind,
  input  logic [7:0]                        in_pixel_in,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]   eff_r,
  input  logic                              q_full,
  output logic                              q_push,
  output cmd_t                              q_data
);

  localparam int LINES = 2*MAX_RADIUS + 2;
  localparam int SLW   = $clog2(LINES);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int HCW   = $clog2(MAX_HEIGHT+1);

  logic [HCW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt;
  logic [RW-1:0]  out_row_r;
  logic [CW-1:0]  out_col_r;
  logic [SLW-1:0] out_slot_r;
  logic           accept;
  logic           store;
  logic           emit;
  logic           last_col;
  logic           last_row;
  logic [31:0]    wm1, hm1, nr, nc;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign store  = (in_kind == sgf_pkg::KIND_PIXEL) && (32'(in_row_r) < 32'(eff_h));
  assign wm1    = 32'(eff_w) - 32'd1;
  assign hm1    = 32'(eff_h) - 32'd1;

  // input position after this item
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    in_slot_nxt = in_slot_r;
    if (store) begin
      if (32'(in_col_r) >= wm1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
        in_slot_nxt = (in_slot_r == SLW'(LINES-1)) ? '0 : in_slot_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
    end
  end

  // an output is due once its whole neighbourhood has arrived
  always_comb begin
    nr = (32'(out_row_r) + 32'(eff_r) > hm1) ? hm1 : 32'(out_row_r) + 32'(eff_r);
    nc = (32'(out_col_r) + 32'(eff_r) > wm1) ? wm1 : 32'(out_col_r) + 32'(eff_r);
    emit = (32'(in_row_nxt) >= 32'(eff_h)) || (32'(in_row_nxt) > nr) ||
           ((32'(in_row_nxt) == nr) && (32'(in_col_nxt) > nc));
  end

  assign last_col = (32'(out_col_r) >= wm1);
  assign last_row = (32'(out_row_r) >= hm1);

  always_comb begin
    q_push           = accept && (store || emit);
    q_data           = '0;
    q_data.store     = store;
    q_data.pix       = in_pixel_in;
    q_data.st_slot   = in_slot_r;
    q_data.st_col    = in_col_r;
    q_data.emit      = emit;
    q_data.frame_end = emit && last_col && last_row;
    q_data.o_row     = out_row_r;
    q_data.o_col     = out_col_r;
    q_data.o_slot    = out_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
    end else if (accept) begin
      if (emit && last_col && last_row) begin
        in_row_r   <= '0;
        in_col_r   <= '0;
        in_slot_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_slot_r <= '0;
      end else begin
        in_row_r  <= in_row_nxt;
        in_col_r  <= in_col_nxt;
        in_slot_r <= in_slot_nxt;
        if (emit) begin
          if (last_col) begin
            out_col_r  <= '0;
            out_row_r  <= out_row_r + 1'b1;
            out_slot_r <= (out_slot_r == SLW'(LINES-1)) ? '0 : out_slot_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/sgf_back.sv =====
module sgf_back #(
  parameter int MAX_RADIUS  = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int WEIGHT_BITS = 16,
  parameter type cmd_t      = logic
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  cmd_t                              q_head,
  output logic                              q_pop,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]    weights_v,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]    weights_h,
  input  logic [sgf_pkg::MODE_W-1:0]        border_mode,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_h,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]   eff_r,
  input  logic                              pop,
  output logic                              empty,
  output logic [7:0]                        out_pixel_out,
  output logic                              out_frame_end
);

  localparam int WB    = WEIGHT_BITS;
  localparam int LINES = 2*MAX_RADIUS + 2;
  localparam int SLW   = $clog2(LINES);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RADW  = $clog2(MAX_RADIUS+1);
  localparam int TAPW  = $clog2(2*MAX_RADIUS+2);
  localparam int PW    = WB + 8;
  localparam int RSW   = PW + TAPW;
  localparam int WSW   = WB + TAPW;
  localparam int AW    = 2*WB + 8 + 2*TAPW;
  localparam int SRW   = RW + 2;
  localparam int SCW   = CW + 2;
  localparam int SH    = 2*(WB-1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TAP, ST_MUL, ST_ROW, ST_FIN, ST_DIV, ST_OUT
  } state_t;

  function automatic logic [WB-1:0] weight_at(input logic [63:0] reg_v,
                                              input logic [RADW-1:0] k);
    logic [63+WB:0] ext;
    int             sh;
    sh  = int'(k) * WB;
    ext = {{WB{1'b0}}, reg_v} >> sh;
    if ((int'(k) > 3) || (sh >= 64)) return '0;
    return ext[WB-1:0];
  endfunction

  state_t                 state_r;
  logic [RW-1:0]          o_row_r;
  logic [CW-1:0]          o_col_r;
  logic [SLW-1:0]         o_slot_r;
  logic                   fe_r;
  logic signed [RADW:0]   a_r, b_r;
  logic [RSW-1:0]         rowsum_r;
  logic [WSW-1:0]         wsum_r;
  logic [AW-1:0]          num_r, den_r, dsh_r;
  logic [7:0]             quo_r;
  logic [3:0]             step_r;
  logic [7:0]             res_r;
  logic                   tap_ok_r;
  logic [WB-1:0]          tap_w_r;
  logic [7:0]             rd_r;
  logic                   out_valid_r;
  logic [7:0]             out_pixel_r;
  logic                   out_fe_r;
  logic [7:0]             mem_r [LINES][MAX_WIDTH];

  logic signed [RADW:0]   r_s;
  logic [RADW-1:0]        a_abs, b_abs;
  logic signed [SRW-1:0]  ri, rr1, rr2, rr3, hm1_s, s_row;
  logic signed [SCW-1:0]  cj, cc1, cc2, cc3, wm1_s;
  logic                   in_bounds;
  logic [SLW-1:0]         tap_slot;
  logic [CW-1:0]          tap_col;
  logic                   mem_we;
  logic [PW-1:0]          tap_prod;
  logic [WB-1:0]          wsv;
  logic [WB+RSW-1:0]      num_prod;
  logic [WB+WSW-1:0]      den_prod;
  logic [AW-1:0]          num_sh;
  logic                   ge;
  logic [8:0]             q9;
  logic                   out_load;

  assign r_s   = $signed({1'b0, eff_r});
  assign a_abs = RADW'(a_r < 0 ? -a_r : a_r);
  assign b_abs = RADW'(b_r < 0 ? -b_r : b_r);
  assign hm1_s = $signed({2'b00, RW'(eff_h - 1'b1)});
  assign wm1_s = $signed({2'b00, CW'(eff_w - 1'b1)});

  // tap position with reflection, clamped into the image
  always_comb begin
    ri  = $signed({2'b00, o_row_r}) + SRW'(a_r);
    rr1 = (ri < 0) ? -ri : ri;
    rr2 = (rr1 > hm1_s) ? (hm1_s <<< 1) - rr1 : rr1;
    rr3 = (rr2 < 0) ? '0 : ((rr2 > hm1_s) ? hm1_s : rr2);
    cj  = $signed({2'b00, o_col_r}) + SCW'(b_r);
    cc1 = (cj < 0) ? -cj : cj;
    cc2 = (cc1 > wm1_s) ? (wm1_s <<< 1) - cc1 : cc1;
    cc3 = (cc2 < 0) ? '0 : ((cc2 > wm1_s) ? wm1_s : cc2);
    in_bounds = (ri >= 0) && (ri <= hm1_s) && (cj >= 0) && (cj <= wm1_s);
    // line slot of the tap row, relative to the output row's slot
    s_row = $signed({{(SRW-SLW){1'b0}}, o_slot_r}) + (rr3 - $signed({2'b00, o_row_r}));
    if (s_row < 0) s_row = s_row + SRW'(LINES);
    else if (s_row >= SRW'(LINES)) s_row = s_row - SRW'(LINES);
    tap_slot = SLW'(s_row);
    tap_col  = CW'(cc3);
  end

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign mem_we   = q_pop && q_head.store;
  assign tap_prod = tap_w_r * rd_r;
  assign wsv      = weight_at(weights_v, a_abs);
  assign num_prod = wsv * rowsum_r;
  assign den_prod = wsv * wsum_r;
  assign num_sh   = num_r >> SH;
  assign ge       = (num_r >= dsh_r);
  assign q9       = {quo_r, ge};
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || pop);

  assign empty         = !out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_fe_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[q_head.st_slot][q_head.st_col] <= q_head.pix;
    end
    rd_r <= mem_r[tap_slot][tap_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (out_load) out_valid_r <= 1'b1;
      else if (pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty && q_head.emit) begin
            o_row_r  <= q_head.o_row;
            o_col_r  <= q_head.o_col;
            o_slot_r <= q_head.o_slot;
            fe_r     <= q_head.frame_end;
            a_r      <= -r_s;
            b_r      <= -r_s;
            rowsum_r <= '0;
            wsum_r   <= '0;
            num_r    <= '0;
            den_r    <= '0;
            state_r  <= ST_TAP;
          end
        end
        ST_TAP: begin
          tap_ok_r <= (border_mode == sgf_pkg::MODE_MIRROR) || in_bounds;
          tap_w_r  <= weight_at(weights_h, b_abs);
          state_r  <= ST_MUL;
        end
        ST_MUL: begin
          if (tap_ok_r) begin
            rowsum_r <= rowsum_r + RSW'(tap_prod);
            wsum_r   <= wsum_r + WSW'(tap_w_r);
          end
          if (b_r == r_s) begin
            state_r <= ST_ROW;
          end else begin
            b_r     <= b_r + 1'b1;
            state_r <= ST_TAP;
          end
        end
        ST_ROW: begin
          num_r    <= num_r + AW'(num_prod);
          den_r    <= den_r + AW'(den_prod);
          rowsum_r <= '0;
          wsum_r   <= '0;
          if (a_r == r_s) begin
            state_r <= ST_FIN;
          end else begin
            a_r     <= a_r + 1'b1;
            b_r     <= -r_s;
            state_r <= ST_TAP;
          end
        end
        ST_FIN: begin
          if (border_mode == sgf_pkg::MODE_RENORM) begin
            if (den_r == '0) begin
              res_r   <= '0;
              state_r <= ST_OUT;
            end else begin
              dsh_r   <= den_r << 8;
              quo_r   <= '0;
              step_r  <= '0;
              state_r <= ST_DIV;
            end
          end else begin
            res_r   <= (num_sh > AW'(255)) ? 8'd255 : num_sh[7:0];
            state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (ge) num_r <= num_r - dsh_r;
          dsh_r  <= dsh_r >> 1;
          quo_r  <= q9[7:0];
          step_r <= step_r + 1'b1;
          if (step_r == 4'd8) begin
            res_r   <= q9[8] ? 8'd255 : q9[7:0];
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_pixel_r <= res_r;
            out_fe_r    <= fe_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/separable_gaussian_filter_3x3_to_7x7_unit.sv =====
// channel   ports                                   direction  transfer when
// input     push, full, in_kind, in_pixel_in        in         push && !full
// result    pop, empty, out_pixel_out, out_frame_end out        pop && !empty
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid && cfg_ready
//
// an item that stores a pixel and owes no output leaves the command queue as soon as the back end is idle
// an output walks its window one tap at a time through the single line-store
// read port, in the states tap and mul for each tap and row after each window row;
// renormalize adds the states of the bit-serial divider
// the front keeps taking items until the four-entry command queue fills
// rst_n is synchronous; the line store is not cleared, every tap read that an output uses hits
// a pixel written earlier in the same frame
module separable_gaussian_filter_3x3_to_7x7_unit #(
  parameter int MAX_RADIUS  = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_kind,
  input  logic [7:0]                         in_pixel_in,
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         out_pixel_out,
  output logic                               out_frame_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LINES = 2*MAX_RADIUS + 2;
  localparam int SLW   = $clog2(LINES);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WCW   = $clog2(MAX_WIDTH+1);
  localparam int HCW   = $clog2(MAX_HEIGHT+1);
  localparam int RADW  = $clog2(MAX_RADIUS+1);

  // one queued command: an optional line-store write and an optional output
  typedef struct packed {
    logic           store;
    logic [7:0]     pix;
    logic [SLW-1:0] st_slot;
    logic [CW-1:0]  st_col;
    logic           emit;
    logic           frame_end;
    logic [RW-1:0]  o_row;
    logic [CW-1:0]  o_col;
    logic [SLW-1:0] o_slot;
  } cmd_t;

  logic [sgf_pkg::CFG_DATA_W-1:0] weights_v_r;
  logic [sgf_pkg::CFG_DATA_W-1:0] weights_h_r;
  logic [sgf_pkg::RAD_REG_W-1:0]  radius_r;
  logic [sgf_pkg::MODE_W-1:0]     border_r;
  logic [sgf_pkg::DIM_W-1:0]      width_r;
  logic [sgf_pkg::DIM_W-1:0]      height_r;
  logic                           cfg_wr;
  logic                           restart;
  logic [WCW-1:0]                 eff_w;
  logic [HCW-1:0]                 eff_h;
  logic [RADW-1:0]                eff_r;
  logic                           q_full, q_empty, q_push, q_pop;
  cmd_t                           q_in, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // geometry writes restart the frame
  assign restart   = cfg_wr && ((cfg_index == sgf_pkg::CFG_RADIUS) ||
                                (cfg_index == sgf_pkg::CFG_WIDTH) ||
                                (cfg_index == sgf_pkg::CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_v_r <= sgf_pkg::CFG_DATA_W'(32768);
      weights_h_r <= sgf_pkg::CFG_DATA_W'(32768);
      radius_r    <= sgf_pkg::RAD_REG_W'(1);
      border_r    <= sgf_pkg::MODE_RENORM;
      width_r     <= sgf_pkg::DIM_W'(512);
      height_r    <= sgf_pkg::DIM_W'(512);
    end else if (cfg_wr) begin
      case (cfg_index)
        sgf_pkg::CFG_WEIGHTS_V: weights_v_r <= cfg_data;
        sgf_pkg::CFG_WEIGHTS_H: weights_h_r <= cfg_data;
        sgf_pkg::CFG_RADIUS:    radius_r    <= cfg_data[sgf_pkg::RAD_REG_W-1:0];
        sgf_pkg::CFG_BORDER:    border_r    <= cfg_data[sgf_pkg::MODE_W-1:0];
        sgf_pkg::CFG_WIDTH:     width_r     <= cfg_data[sgf_pkg::DIM_W-1:0];
        sgf_pkg::CFG_HEIGHT:    height_r    <= cfg_data[sgf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry into what the line store holds
  always_comb begin
    if (width_r == '0) eff_w = WCW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) eff_w = WCW'(MAX_WIDTH);
    else eff_w = WCW'(width_r);
    if (height_r == '0) eff_h = HCW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) eff_h = HCW'(MAX_HEIGHT);
    else eff_h = HCW'(height_r);
    if (32'(radius_r) > 32'(MAX_RADIUS)) eff_r = RADW'(MAX_RADIUS);
    else eff_r = RADW'(radius_r);
  end

  sgf_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .cmd_t      (cmd_t)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_kind     (in_kind),
    .in_pixel_in (in_pixel_in),
    .restart     (restart),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .eff_r       (eff_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  sgf_cmd_fifo #(
    .T (cmd_t)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sgf_back #(
    .MAX_RADIUS  (MAX_RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .weights_v     (weights_v_r),
    .weights_h     (weights_h_r),
    .border_mode   (border_r),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .eff_r         (eff_r),
    .pop           (pop),
    .empty         (empty),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

endmodule
